// ===== hdl/bbra_pkg.sv =====
package bbra_pkg;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_GET  = 2'd1,
		OP_IDLE = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SRV_NONE = 2'd0,
		SRV_PUT  = 2'd1,
		SRV_GET  = 2'd2,
		SRV_RSVD = 2'd3
	} srv_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] requester;
		logic [7:0] put_value;
	} req_item_t;

	typedef struct packed {
		logic [1:0]       served;
		logic [7:0]       served_requester;
		logic [7:0]       data_value;
		logic [CAP_W-1:0] occupancy;
		logic             dropped;
	} rsp_item_t;

	typedef struct packed {
		logic push_ok;
		logic waiting;
	} q_stat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} buf_stat_t;

endpackage

// ===== hdl/bbra_req_queue.sv =====
module bbra_req_queue #(
	parameter int DEPTH = 16,
	parameter int W     = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_req,
	input  logic [W-1:0]      push_data,
	input  logic              pop,
	output bbra_pkg::q_stat_t stat,
	output logic [W-1:0]      head_data
);
	import bbra_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 2;

	logic [W-1:0]     mem [DEPTH];
	logic [W-1:0]     hd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] next_head;
	logic             push_ok;

	assign push_ok = push_req && (count_q != CNT_W'(DEPTH));
	assign sum     = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail    = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

	always_comb begin
		next_head = head_q;
		if (pop) begin
			next_head = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		end
	end

	// An empty queue serves the item pushed in this same step.
	assign head_data    = (count_q == '0) ? push_data : hd_q;
	assign stat.push_ok = push_ok;
	assign stat.waiting = (count_q != '0) || push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= next_head;
			count_q <= count_q + CNT_W'(push_ok) - CNT_W'(pop);
		end
	end

	// The head entry is prefetched into a register from the next head pointer; a write to the next head bypasses.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[tail] <= push_data;
		end
		if (push_ok && (tail == next_head)) begin
			hd_q <= push_data;
		end else begin
			hd_q <= mem[next_head];
		end
	end

endmodule

// ===== hdl/bbra_data_buf.sv =====
module bbra_data_buf #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bbra_pkg::CAP_W-1:0]     capacity,
	input  logic                           put,
	input  logic                           get,
	input  logic [7:0]                     wdata,
	output bbra_pkg::buf_stat_t            stat,
	output logic [7:0]                     rdata,
	output logic [bbra_pkg::CAP_W-1:0]     occupancy
);
	import bbra_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 2;

	logic [7:0]       mem [DEPTH];
	logic [7:0]       hd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [CNT_W-1:0] eff_cap;
	logic [SUM_W-1:0] sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] next_head;

	// A capacity of zero acts as one; above the depth it acts as the depth.
	always_comb begin
		priority if (32'(capacity) > DEPTH) begin
			eff_cap = CNT_W'(DEPTH);
		end else if (capacity == '0) begin
			eff_cap = CNT_W'(1);
		end else begin
			eff_cap = CNT_W'(capacity);
		end
	end

	assign stat.full  = count_q >= eff_cap;
	assign stat.empty = count_q == '0;

	assign sum        = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail       = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);
	assign count_next = count_q + CNT_W'(put) - CNT_W'(get);
	assign occupancy  = CAP_W'(count_next);
	assign rdata      = hd_q;

	always_comb begin
		next_head = head_q;
		if (get) begin
			next_head = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= next_head;
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			mem[tail] <= wdata;
		end
		if (put && (tail == next_head)) begin
			hd_q <= wdata;
		end else begin
			hd_q <= mem[next_head];
		end
	end

endmodule

// ===== hdl/bounded_buffer_request_arbiter.sv =====
// A request item is captured in the input register; its result is offered from the result register.
// Throughput: one item per cycle; the input register and the result register
// step together whenever the result register is empty or being taken.
// Reset (arst_n low, asynchronous): queues and data buffer empty, arrival
// stamp zero, capacity 16. Stored entries are not cleared and need no pass.
module bounded_buffer_request_arbiter #(
	parameter int BUF_DEPTH  = 16,
	parameter int REQ_DEPTH  = 16,
	parameter int STAMP_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bbra_pkg::req_item_t        req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bbra_pkg::rsp_item_t        rsp,
	input  logic                       capacity_we,
	input  logic [bbra_pkg::CAP_W-1:0] capacity_wdata
);
	import bbra_pkg::*;

	localparam int PUT_W = 16 + STAMP_BITS;
	localparam int GET_W = 8 + STAMP_BITS;

	req_item_t             req_s1;
	logic                  valid_s1;
	rsp_item_t             rsp_s2;
	logic                  valid_s2;
	logic [CAP_W-1:0]      capacity_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  advance;

	q_stat_t               pq_stat;
	q_stat_t               gq_stat;
	buf_stat_t             buf_stat;
	logic [PUT_W-1:0]      pq_head;
	logic [GET_W-1:0]      gq_head;
	logic [7:0]            buf_rdata;
	logic [CAP_W-1:0]      occ_next;
	logic [STAMP_BITS-1:0] stamp_diff;
	logic                  put_req;
	logic                  get_req;
	logic                  do_put;
	logic                  do_get;
	rsp_item_t             rsp_next;

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign put_req   = advance && (req_s1.op == OP_PUT);
	assign get_req   = advance && (req_s1.op == OP_GET);

	bbra_req_queue #(.DEPTH(REQ_DEPTH), .W(PUT_W)) u_put_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (put_req),
		.push_data ({req_s1.requester, req_s1.put_value, stamp_q}),
		.pop       (do_put),
		.stat      (pq_stat),
		.head_data (pq_head)
	);

	bbra_req_queue #(.DEPTH(REQ_DEPTH), .W(GET_W)) u_get_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_req  (get_req),
		.push_data ({req_s1.requester, stamp_q}),
		.pop       (do_get),
		.stat      (gq_stat),
		.head_data (gq_head)
	);

	bbra_data_buf #(.DEPTH(BUF_DEPTH)) u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.put       (do_put),
		.get       (do_get),
		.wdata     (pq_head[STAMP_BITS +: 8]),
		.stat      (buf_stat),
		.rdata     (buf_rdata),
		.occupancy (occ_next)
	);

	// Stamps wrap, so the older one is the one whose modular difference is negative.
	assign stamp_diff = pq_head[STAMP_BITS-1:0] - gq_head[STAMP_BITS-1:0];

	always_comb begin
		do_put = 1'b0;
		do_get = 1'b0;
		if (advance) begin
			priority if (pq_stat.waiting && !gq_stat.waiting) begin
				do_put = !buf_stat.full;
			end else if (gq_stat.waiting && !pq_stat.waiting) begin
				do_get = !buf_stat.empty;
			end else if (pq_stat.waiting && gq_stat.waiting) begin
				priority if (buf_stat.empty) begin
					do_put = 1'b1;
				end else if (buf_stat.full) begin
					do_get = 1'b1;
				end else if (stamp_diff[STAMP_BITS-1]) begin
					do_put = 1'b1;
				end else begin
					do_get = 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp_next.served           = SRV_NONE;
		rsp_next.served_requester = '0;
		rsp_next.data_value       = '0;
		rsp_next.occupancy        = occ_next;
		rsp_next.dropped          = (put_req && !pq_stat.push_ok) ||
		                            (get_req && !gq_stat.push_ok);
		if (do_put) begin
			rsp_next.served           = SRV_PUT;
			rsp_next.served_requester = pq_head[PUT_W-1 -: 8];
			rsp_next.data_value       = pq_head[STAMP_BITS +: 8];
		end else if (do_get) begin
			rsp_next.served           = SRV_GET;
			rsp_next.served_requester = gq_head[GET_W-1 -: 8];
			rsp_next.data_value       = buf_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			capacity_q <= CAP_RESET;
			stamp_q    <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
			if (pq_stat.push_ok || gq_stat.push_ok) begin
				stamp_q <= stamp_q + STAMP_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_put_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_put |-> !buf_stat.full)
		else $error("put served into a full data buffer");

	a_get_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		do_get |-> !buf_stat.empty)
		else $error("get served from an empty data buffer");

	a_stamp_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stamp_q) |-> $past(pq_stat.push_ok || gq_stat.push_ok))
		else $error("arrival stamp moved without a queued request");

	a_one_serve: assert property (@(posedge clk) disable iff (!arst_n)
		(do_put || do_get) |-> advance && !(do_put && do_get))
		else $error("serve outside a step or both serves at once");

endmodule

// ===== dv/tb_bounded_buffer_request_arbiter.sv =====
`timescale 1ns / 100ps

module tb_bounded_buffer_request_arbiter;

	import bbra_pkg::*;

	localparam int BUF_DEPTH = 16;
	localparam int REQ_DEPTH = 16;
	localparam int STAMP_BITS = 8;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned PHASE_COUNT = 10;

	typedef enum int {
		MIX_BALANCED,
		MIX_PUT_HEAVY,
		MIX_GET_HEAVY
	} mix_t;

	typedef struct {
		logic [7:0]            who;
		logic [7:0]            val;
		logic [STAMP_BITS-1:0] stamp;
	} waiting_req_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_item_t        req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_item_t        rsp;
	logic             capacity_we = 1'b0;
	logic [CAP_W-1:0] capacity_wdata = '0;

	// Shadow state of the arbiter.
	logic [CAP_W-1:0]      capacity_shadow = CAP_RESET;
	logic [7:0]            data_shadow [BUF_DEPTH];
	int unsigned           data_count = 0;
	int unsigned           data_head = 0;
	waiting_req_t          put_waiting [$];
	waiting_req_t          get_waiting [$];
	logic [STAMP_BITS-1:0] stamp_counter = '0;

	rsp_item_t   expected_results [$];
	int unsigned error_count = 0;
	int unsigned backpressure_len = 0;
	bit          sender_gaps = 1'b1;

	bounded_buffer_request_arbiter #(
		.BUF_DEPTH(BUF_DEPTH),
		.REQ_DEPTH(REQ_DEPTH),
		.STAMP_BITS(STAMP_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.capacity_we(capacity_we),
		.capacity_wdata(capacity_wdata)
	);

	always #2 clk = ~clk;

	function automatic int unsigned effective_capacity();
		if (capacity_shadow == 0)
			return 1;
		if (capacity_shadow > BUF_DEPTH)
			return BUF_DEPTH;
		return capacity_shadow;
	endfunction

	// Queues the new request, then serves at most one waiting request.
	function void predict_step(req_item_t item);
		rsp_item_t             result;
		waiting_req_t          entry;
		logic [STAMP_BITS-1:0] stamp_diff;
		bit                    full;
		bit                    take_put;
		bit                    take_get;
		result = '0;
		entry.who = item.requester;
		entry.val = item.put_value;
		entry.stamp = stamp_counter;
		case (op_t'(item.op))
			OP_PUT: begin
				if (put_waiting.size() >= REQ_DEPTH) begin
					result.dropped = 1'b1;
				end else begin
					put_waiting.push_back(entry);
					stamp_counter++;
				end
			end
			OP_GET: begin
				if (get_waiting.size() >= REQ_DEPTH) begin
					result.dropped = 1'b1;
				end else begin
					get_waiting.push_back(entry);
					stamp_counter++;
				end
			end
			default: begin
			end
		endcase
		full = data_count >= effective_capacity();
		take_put = 1'b0;
		take_get = 1'b0;
		if (put_waiting.size() != 0 && get_waiting.size() == 0) begin
			take_put = !full;
		end else if (get_waiting.size() != 0 && put_waiting.size() == 0) begin
			take_get = data_count != 0;
		end else if (put_waiting.size() != 0 && get_waiting.size() != 0) begin
			if (data_count == 0) begin
				take_put = 1'b1;
			end else if (full) begin
				take_get = 1'b1;
			end else begin
				// A negative modular difference means the put arrived first.
				stamp_diff = put_waiting[0].stamp - get_waiting[0].stamp;
				if (stamp_diff[STAMP_BITS-1])
					take_put = 1'b1;
				else
					take_get = 1'b1;
			end
		end
		if (take_put) begin
			entry = put_waiting.pop_front();
			data_shadow[(data_head + data_count) % BUF_DEPTH] = entry.val;
			data_count++;
			result.served = SRV_PUT;
			result.served_requester = entry.who;
			result.data_value = entry.val;
		end else if (take_get) begin
			entry = get_waiting.pop_front();
			result.data_value = data_shadow[data_head];
			data_head = (data_head + 1) % BUF_DEPTH;
			data_count--;
			result.served = SRV_GET;
			result.served_requester = entry.who;
		end
		result.occupancy = data_count[CAP_W-1:0];
		expected_results.push_back(result);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (!sender_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic op_t pick_op(mix_t mix);
		int unsigned roll;
		int unsigned put_share;
		int unsigned get_share;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_PUT_HEAVY: begin
				put_share = 75;
				get_share = 18;
			end
			MIX_GET_HEAVY: begin
				put_share = 20;
				get_share = 72;
			end
			default: begin
				put_share = 45;
				get_share = 45;
			end
		endcase
		if (roll < put_share)
			return OP_PUT;
		if (roll < put_share + get_share)
			return OP_GET;
		if (roll < 97)
			return OP_IDLE;
		return OP_RSVD;
	endfunction

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_request(input op_t op, input logic [7:0] who, input logic [7:0] val);
		req_item_t   item;
		int unsigned gap;
		bit          taken;
		item.op = op;
		item.requester = who;
		item.put_value = val;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(negedge clk);
			taken = req_ready;
			if (taken)
				predict_step(item);
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] value);
		wait_idle();
		capacity_we <= 1'b1;
		capacity_wdata <= value;
		capacity_shadow = value;
		@(posedge clk);
		capacity_we <= 1'b0;
	endtask

	task automatic test_directed_ops();
		send_request(OP_GET, 8'hFF, 8'h00);
		send_request(OP_PUT, 8'h00, 8'h00);
		send_request(OP_IDLE, 8'h12, 8'h34);
		send_request(OP_PUT, 8'hFF, 8'hFF);
		send_request(OP_RSVD, 8'hFF, 8'hFF);
		send_request(OP_PUT, 8'hA5, 8'h5A);
		send_request(OP_GET, 8'h5A, 8'hA5);
		send_request(OP_GET, 8'h01, 8'h80);
		send_request(OP_GET, 8'h80, 8'h01);
	endtask

	task automatic test_capacity_limits();
		set_capacity(5'd1);
		send_request(OP_PUT, 8'h10, 8'h11);
		send_request(OP_PUT, 8'h20, 8'h22);
		send_request(OP_GET, 8'h30, 8'h00);
		send_request(OP_IDLE, 8'h00, 8'h00);
		send_request(OP_GET, 8'h40, 8'h00);
		// Zero acts as one entry.
		set_capacity(5'd0);
		send_request(OP_PUT, 8'h50, 8'h55);
		send_request(OP_PUT, 8'h60, 8'h66);
		send_request(OP_GET, 8'h70, 8'h00);
		// Fill three entries, then lower the limit below the occupancy.
		set_capacity(5'd31);
		send_request(OP_PUT, 8'h01, 8'hC1);
		send_request(OP_PUT, 8'h02, 8'hC2);
		send_request(OP_PUT, 8'h03, 8'hC3);
		set_capacity(5'd1);
		send_request(OP_PUT, 8'h04, 8'hC4);
		send_request(OP_GET, 8'h05, 8'h00);
		send_request(OP_GET, 8'h06, 8'h00);
		send_request(OP_GET, 8'h07, 8'h00);
	endtask

	task automatic test_receiver_backpressure();
		int unsigned n;
		set_capacity(5'd16);
		sender_gaps = 1'b0;
		backpressure_len <= 300;
		for (n = 0; n < 40; n++)
			send_request(pick_op(MIX_BALANCED), 8'($urandom), 8'($urandom));
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] phase_caps [7];
		logic [CAP_W-1:0] cap;
		mix_t             mix;
		int unsigned      phase;
		int unsigned      n;
		phase_caps = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd1};
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase < 7)
				cap = phase_caps[phase];
			else
				cap = CAP_W'($urandom_range(0, 31));
			set_capacity(cap);
			mix = mix_t'(phase % 3);
			sender_gaps = $urandom_range(0, 3) != 0;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_op(mix), 8'($urandom), 8'($urandom));
		end
		sender_gaps = 1'b1;
	endtask

	// Result side: random stalls, quiet stretches, and long hold-offs on request.
	initial begin
		int unsigned hold;
		int unsigned quiet;
		int unsigned roll;
		hold = 0;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (backpressure_len != 0) begin
				hold = backpressure_len;
				backpressure_len <= 0;
			end
			if (hold != 0) begin
				rsp_ready <= 1'b0;
				hold--;
			end else if (quiet != 0) begin
				rsp_ready <= 1'b1;
				quiet--;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					rsp_ready <= 1'b1;
				end else if (roll < 80) begin
					quiet = $urandom_range(20, 80);
					rsp_ready <= 1'b1;
				end else if (roll < 97) begin
					hold = $urandom_range(0, 2);
					rsp_ready <= 1'b0;
				end else begin
					hold = $urandom_range(10, 40);
					rsp_ready <= 1'b0;
				end
			end
		end
	end

	// Outputs are stable at the falling edge; a result seen here is taken at the next rise.
	initial begin
		rsp_item_t want;
		forever begin
			@(negedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no pending request: %p", rsp);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.served !== want.served) begin
						$error("served: expected %0d, actual %0d", want.served, rsp.served);
						error_count++;
					end
					if (rsp.served_requester !== want.served_requester) begin
						$error("served_requester: expected %0d, actual %0d",
							want.served_requester, rsp.served_requester);
						error_count++;
					end
					if (rsp.data_value !== want.data_value) begin
						$error("data_value: expected %0d, actual %0d",
							want.data_value, rsp.data_value);
						error_count++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d",
							want.occupancy, rsp.occupancy);
						error_count++;
					end
					if (rsp.dropped !== want.dropped) begin
						$error("dropped: expected %0d, actual %0d", want.dropped, rsp.dropped);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(negedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_capacity_limits();
		test_receiver_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (10) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
